// File: rtl/fcb_pkg.sv
// Shared constants, register codes, types and helpers for the fit-or-crop blit.
// Depends on nothing; every other file refers to it by scoped names.
package fcb_pkg;

  localparam int MAX_DIM     = 4096;
  localparam int DIM_W       = $clog2(MAX_DIM) + 1;   // holds MAX_DIM itself
  localparam int COL_W       = $clog2(MAX_DIM);       // holds 0 .. MAX_DIM-1
  localparam int CFG_W       = 13;
  localparam int CFG_IDX_W   = 3;
  localparam int ADDR_W      = 24;
  localparam int PIX_W       = 32;
  localparam int PROD_W      = ADDR_W + DIM_W;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int DIV_CNT_W   = $clog2(DIM_W + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCREEN_WIDTH  = 3'd0,
    REG_SCREEN_HEIGHT = 3'd1,
    REG_IMAGE_WIDTH   = 3'd2,
    REG_IMAGE_HEIGHT  = 3'd3,
    REG_SCALE_MODE    = 3'd4
  } cfg_reg_t;

  localparam logic [CFG_W-1:0] RST_SCREEN_WIDTH  = 13'd640;
  localparam logic [CFG_W-1:0] RST_SCREEN_HEIGHT = 13'd480;
  localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH   = 13'd640;
  localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT  = 13'd480;

  localparam logic MODE_FIT  = 1'b0;
  localparam logic MODE_CROP = 1'b1;

  // Picture geometry for one mode / step combination.
  typedef struct packed {
    logic [DIM_W-1:0]  dw;
    logic [DIM_W-1:0]  dh;
    logic [ADDR_W-1:0] ox;
    logic [ADDR_W-1:0] oy;
    logic [ADDR_W-1:0] total_m1;
  } geom_set_t;

  typedef struct packed {
    logic             busy;
    logic             mode;
    logic [DIM_W-1:0] sw;
    logic [DIM_W-1:0] iw;
    logic [DIM_W-1:0] ih;
    logic [DIM_W-1:0] step_cur;
    logic [DIM_W-1:0] step_new;
    logic [DIM_W-1:0] sx0;
    logic [DIM_W-1:0] sy0;
    geom_set_t        crop;
    geom_set_t        fit_cur;
    geom_set_t        fit_new;
  } geom_t;

  typedef struct packed {
    logic [ADDR_W-1:0] row_term;
    logic [ADDR_W-1:0] col_term;
    logic [PIX_W-1:0]  pixel;
    logic              done;
  } entry_t;

  // Saturate a size register into 1 .. MAX_DIM.
  function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] raw);
    logic [DIM_W-1:0] res;
    if (raw == '0) begin
      res = DIM_W'(1);
    end else if (int'(raw) > MAX_DIM) begin
      res = DIM_W'(MAX_DIM);
    end else begin
      res = DIM_W'(raw);
    end
    return res;
  endfunction

  // Centering offset (outer - inner) / 2, wrapping like a 25-bit difference.
  function automatic logic [ADDR_W-1:0] center_off(input logic [DIM_W-1:0] outer,
                                                   input logic [DIM_W-1:0] inner);
    logic [ADDR_W:0] diff;
    diff = (ADDR_W+1)'(outer) - (ADDR_W+1)'(inner);
    return diff[ADDR_W:1];
  endfunction

endpackage

// File: rtl/fcb_pix_if.sv
// Source pixel channel: valid/ready with pixel and frame-start mark.
// Depends on fcb_pkg for widths.
interface fcb_pix_if;
  logic                     valid;
  logic                     ready;
  logic [fcb_pkg::PIX_W-1:0] pixel_in;
  logic                     frame_start;

  modport source (output valid, output pixel_in, output frame_start, input ready);
  modport sink   (input valid, input pixel_in, input frame_start, output ready);
endinterface

// File: rtl/fcb_res_if.sv
// Result channel: valid/ready with framebuffer address, pixel and frame-done flag.
// Depends on fcb_pkg for widths.
interface fcb_res_if;
  logic                      valid;
  logic                      ready;
  logic [fcb_pkg::ADDR_W-1:0] dest_addr;
  logic [fcb_pkg::PIX_W-1:0]  pixel_out;
  logic                      frame_done;

  modport source (output valid, output dest_addr, output pixel_out, output frame_done,
                  input ready);
  modport sink   (input valid, input dest_addr, input pixel_out, input frame_done,
                  output ready);
endinterface

// File: rtl/fcb_cfg_if.sv
// Configuration write channel: valid/ready with register index and data.
// Depends on fcb_pkg for widths.
interface fcb_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [fcb_pkg::CFG_IDX_W-1:0] index;
  logic [fcb_pkg::CFG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/fit_or_crop_center_blit.sv
// Top level of the centered fit-or-crop blit: geometry unit, front end, queue, back end.
// Depends on fcb_pkg, the three channel interfaces, fcb_geom, fcb_front, fcb_queue, fcb_back.
//
//  channel  | dir | transaction carries                       | handshake
//  ---------+-----+-------------------------------------------+-----------------
//  in_ch    | in  | pixel_in[31:0], frame_start               | valid & ready
//  out_ch   | out | dest_addr[23:0], pixel_out[31:0], frame_done | valid & ready
//  cfg_ch   | in  | index[2:0], data[12:0]                    | valid & ready
//
// One pixel transaction per cycle sustained while the geometry unit is idle and out_ch
// does not stall; a kept pixel passes through queue write, row multiply and address add.
// Every configuration write, and reset itself, starts a geometry pass of six serial
// divisions and three area multiplies; in_ch.ready stays low for that pass.
// cfg_ch.ready is always high.
// Reset is synchronous, active low. A stall on out_ch fills the output stage, the
// row-multiply stage and the four-entry queue (six kept pixels) before in_ch.ready
// drops; while the queue is full in_ch.ready stays low for dropped pixels too.
module fit_or_crop_center_blit (
  input  logic       clk,
  input  logic       rst_n,
  fcb_pix_if.sink    in_ch,
  fcb_res_if.source  out_ch,
  fcb_cfg_if.sink    cfg_ch
);

  fcb_pkg::geom_t   geom;
  fcb_pkg::entry_t  q_entry, q_head;
  logic             fs_take, q_push, q_full, q_pop, q_not_empty;

  // Hold the registers; recompute fit step, picture sizes and centering offsets.
  fcb_geom u_geom (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_ch),
    .fs_take (fs_take),
    .geom    (geom)
  );

  // Track the raster position and classify each pixel as kept or dropped.
  // Dropped pixels (and pixels past the last source row) never reach the queue.
  fcb_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .geom    (geom),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (q_entry),
    .fs_take (fs_take)
  );

  // Decouple the classifier from the address pipeline.
  fcb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .not_empty  (q_not_empty),
    .head       (q_head)
  );

  // Form row * screen_width + column and present the result transaction.
  fcb_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_not_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .sw      (geom.sw),
    .out_ch  (out_ch)
  );

endmodule

// File: rtl/fcb_div.sv
// Restoring divider, one quotient bit per cycle, for the geometry unit.
// Depends on fcb_pkg for widths.
module fcb_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [fcb_pkg::DIM_W-1:0] num,
  input  logic [fcb_pkg::DIM_W-1:0] den,
  output logic                      done,
  output logic [fcb_pkg::DIM_W-1:0] quo,
  output logic [fcb_pkg::DIM_W-1:0] rem
);

  logic [fcb_pkg::DIM_W-1:0]     rem_r, quo_r, den_r;
  logic [fcb_pkg::DIM_W-1:0]     rem_nxt, quo_nxt;
  logic [fcb_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                          busy_r;
  logic [fcb_pkg::DIM_W:0]       rem_sh;
  logic                          fits;

  always_comb begin
    rem_sh  = {rem_r, quo_r[fcb_pkg::DIM_W-1]};
    fits    = rem_sh >= {1'b0, den_r};
    rem_nxt = fits ? fcb_pkg::DIM_W'(rem_sh - {1'b0, den_r})
                   : fcb_pkg::DIM_W'(rem_sh);
    quo_nxt = {quo_r[fcb_pkg::DIM_W-2:0], fits};
  end

  assign done = busy_r && (cnt_r == fcb_pkg::DIV_CNT_W'(1)) && !start;
  assign quo  = quo_nxt;
  assign rem  = rem_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      rem_r  <= '0;
      quo_r  <= num;
      den_r  <= den;
      cnt_r  <= fcb_pkg::DIV_CNT_W'(fcb_pkg::DIM_W);
      busy_r <= 1'b1;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      cnt_r <= cnt_r - fcb_pkg::DIV_CNT_W'(1);
      if (cnt_r == fcb_pkg::DIV_CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/fcb_geom.sv
// Configuration registers and geometry sequencer: derives steps, sizes, offsets.
// Depends on fcb_pkg, fcb_cfg_if and fcb_div.
module fcb_geom (
  input  logic            clk,
  input  logic            rst_n,
  fcb_cfg_if.sink         cfg,
  input  logic            fs_take,
  output fcb_pkg::geom_t  geom
);

  typedef enum logic [3:0] {
    S_IDLE, S_CEIL_W, S_CEIL_H, S_FIT_W, S_FIT_H, S_CUR_W, S_CUR_H,
    S_MUL_CROP, S_MUL_FIT, S_MUL_CUR
  } state_t;

  state_t                        state_r;
  logic                          start_r;
  logic [fcb_pkg::CFG_W-1:0]     sw_raw_r, sh_raw_r, iw_raw_r, ih_raw_r;
  logic                          mode_r;
  logic [fcb_pkg::DIM_W-1:0]     sw, sh, iw, ih;
  logic [fcb_pkg::DIM_W-1:0]     ceil_w_r, step_new_r, step_cur_r;
  logic [fcb_pkg::DIM_W-1:0]     sx0_r, sy0_r;
  fcb_pkg::geom_set_t            crop_r, fit_new_r, fit_cur_r;
  logic [fcb_pkg::DIM_W-1:0]     div_num, div_den, div_quo, div_rem, ceil_q;
  logic                          div_done;
  logic [fcb_pkg::DIM_W-1:0]     cdw, cdh, mul_a, mul_b;
  logic [2*fcb_pkg::DIM_W-1:0]   mul_p;
  logic [fcb_pkg::ADDR_W-1:0]    tot_m1;
  logic                          cfg_take;

  assign sw = fcb_pkg::eff_dim(sw_raw_r);
  assign sh = fcb_pkg::eff_dim(sh_raw_r);
  assign iw = fcb_pkg::eff_dim(iw_raw_r);
  assign ih = fcb_pkg::eff_dim(ih_raw_r);

  assign cfg.ready = 1'b1;
  assign cfg_take  = cfg.valid && cfg.ready;

  assign cdw = (iw < sw) ? iw : sw;
  assign cdh = (ih < sh) ? ih : sh;

  always_comb begin
    div_num = iw;
    div_den = sw;
    case (state_r)
      S_CEIL_W: begin div_num = iw; div_den = sw;         end
      S_CEIL_H: begin div_num = ih; div_den = sh;         end
      S_FIT_W:  begin div_num = iw; div_den = step_new_r; end
      S_FIT_H:  begin div_num = ih; div_den = step_new_r; end
      S_CUR_W:  begin div_num = iw; div_den = step_cur_r; end
      S_CUR_H:  begin div_num = ih; div_den = step_cur_r; end
      default:  begin div_num = iw; div_den = sw;         end
    endcase
  end

  assign ceil_q = div_quo + fcb_pkg::DIM_W'(div_rem != '0);

  fcb_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_r),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  // One shared multiplier for the three picture areas.
  always_comb begin
    mul_a = cdw;
    mul_b = cdh;
    case (state_r)
      S_MUL_CROP: begin mul_a = cdw;          mul_b = cdh;          end
      S_MUL_FIT:  begin mul_a = fit_new_r.dw; mul_b = fit_new_r.dh; end
      S_MUL_CUR:  begin mul_a = fit_cur_r.dw; mul_b = fit_cur_r.dh; end
      default:    begin mul_a = cdw;          mul_b = cdh;          end
    endcase
    mul_p  = mul_a * mul_b;
    tot_m1 = fcb_pkg::ADDR_W'(mul_p) - fcb_pkg::ADDR_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_raw_r   <= fcb_pkg::RST_SCREEN_WIDTH;
      sh_raw_r   <= fcb_pkg::RST_SCREEN_HEIGHT;
      iw_raw_r   <= fcb_pkg::RST_IMAGE_WIDTH;
      ih_raw_r   <= fcb_pkg::RST_IMAGE_HEIGHT;
      mode_r     <= fcb_pkg::MODE_FIT;
      step_cur_r <= fcb_pkg::DIM_W'(1);
      state_r    <= S_CEIL_W;
      start_r    <= 1'b1;
    end else begin
      start_r <= 1'b0;
      if (fs_take) begin
        step_cur_r <= step_new_r;
        fit_cur_r  <= fit_new_r;
      end
      if (cfg_take) begin
        case (cfg.index)
          fcb_pkg::REG_SCREEN_WIDTH:  sw_raw_r <= cfg.data;
          fcb_pkg::REG_SCREEN_HEIGHT: sh_raw_r <= cfg.data;
          fcb_pkg::REG_IMAGE_WIDTH:   iw_raw_r <= cfg.data;
          fcb_pkg::REG_IMAGE_HEIGHT:  ih_raw_r <= cfg.data;
          fcb_pkg::REG_SCALE_MODE:    mode_r   <= cfg.data[0];
          default: ;
        endcase
        state_r <= S_CEIL_W;
        start_r <= 1'b1;
      end else begin
        case (state_r)
          S_IDLE: ;
          S_CEIL_W: if (div_done) begin
            ceil_w_r <= ceil_q;
            state_r  <= S_CEIL_H;
            start_r  <= 1'b1;
          end
          S_CEIL_H: if (div_done) begin
            step_new_r <= (ceil_q > ceil_w_r) ? ceil_q : ceil_w_r;
            state_r    <= S_FIT_W;
            start_r    <= 1'b1;
          end
          S_FIT_W: if (div_done) begin
            fit_new_r.dw <= div_quo;
            state_r      <= S_FIT_H;
            start_r      <= 1'b1;
          end
          S_FIT_H: if (div_done) begin
            fit_new_r.dh <= div_quo;
            state_r      <= S_CUR_W;
            start_r      <= 1'b1;
          end
          S_CUR_W: if (div_done) begin
            fit_cur_r.dw <= div_quo;
            state_r      <= S_CUR_H;
            start_r      <= 1'b1;
          end
          S_CUR_H: if (div_done) begin
            fit_cur_r.dh <= div_quo;
            state_r      <= S_MUL_CROP;
          end
          S_MUL_CROP: begin
            crop_r.dw       <= cdw;
            crop_r.dh       <= cdh;
            crop_r.ox       <= fcb_pkg::center_off(sw, cdw);
            crop_r.oy       <= fcb_pkg::center_off(sh, cdh);
            crop_r.total_m1 <= tot_m1;
            sx0_r           <= (iw - cdw) >> 1;
            sy0_r           <= (ih - cdh) >> 1;
            state_r         <= S_MUL_FIT;
          end
          S_MUL_FIT: begin
            fit_new_r.ox       <= fcb_pkg::center_off(sw, fit_new_r.dw);
            fit_new_r.oy       <= fcb_pkg::center_off(sh, fit_new_r.dh);
            fit_new_r.total_m1 <= tot_m1;
            state_r            <= S_MUL_CUR;
          end
          S_MUL_CUR: begin
            fit_cur_r.ox       <= fcb_pkg::center_off(sw, fit_cur_r.dw);
            fit_cur_r.oy       <= fcb_pkg::center_off(sh, fit_cur_r.dh);
            fit_cur_r.total_m1 <= tot_m1;
            state_r            <= S_IDLE;
          end
          default: state_r <= S_IDLE;
        endcase
      end
    end
  end

  always_comb begin
    geom.busy     = state_r != S_IDLE;
    geom.mode     = mode_r;
    geom.sw       = sw;
    geom.iw       = iw;
    geom.ih       = ih;
    geom.step_cur = step_cur_r;
    geom.step_new = step_new_r;
    geom.sx0      = sx0_r;
    geom.sy0      = sy0_r;
    geom.crop     = crop_r;
    geom.fit_cur  = fit_cur_r;
    geom.fit_new  = fit_new_r;
  end

endmodule

// File: rtl/fcb_front.sv
// Front end: accepts source pixels, tracks position, decides which are kept.
// Depends on fcb_pkg and fcb_pix_if; feeds the queue.
module fcb_front (
  input  logic             clk,
  input  logic             rst_n,
  fcb_pix_if.sink          in_ch,
  input  fcb_pkg::geom_t   geom,
  input  logic             q_full,
  output logic             q_push,
  output fcb_pkg::entry_t  q_entry,
  output logic             fs_take
);

  logic [fcb_pkg::COL_W-1:0]  col_r, col_ph_r, col_q_r, row_ph_r, row_q_r;
  logic [fcb_pkg::DIM_W-1:0]  row_r;
  logic [fcb_pkg::ADDR_W-1:0] cnt_r;
  logic [fcb_pkg::COL_W-1:0]  col_nxt, col_ph_nxt, col_q_nxt, row_ph_nxt, row_q_nxt;
  logic [fcb_pkg::DIM_W-1:0]  row_nxt;
  logic [fcb_pkg::ADDR_W-1:0] cnt_nxt;

  logic [fcb_pkg::COL_W-1:0]  col_u, col_ph_u, col_q_u, row_ph_u, row_q_u;
  logic [fcb_pkg::DIM_W-1:0]  row_u, step_u;
  logic [fcb_pkg::ADDR_W-1:0] cnt_u;
  fcb_pkg::geom_set_t         fset, gset;
  logic                       fs, take, live, keep, fit_keep, crop_keep;
  logic                       col_wrap, col_ph_wrap, row_ph_wrap;
  logic [fcb_pkg::DIM_W-1:0]  col_inc, col_ph_inc, row_ph_inc;
  logic [fcb_pkg::DIM_W-1:0]  dxc, dyc, dx, dy;

  assign in_ch.ready = !geom.busy && !q_full;
  assign take        = in_ch.valid && in_ch.ready;
  assign fs          = in_ch.frame_start;
  assign fs_take     = take && fs;

  always_comb begin
    // A frame start restarts every counter and switches to the fresh fit step.
    col_u    = fs ? '0 : col_r;
    col_ph_u = fs ? '0 : col_ph_r;
    col_q_u  = fs ? '0 : col_q_r;
    row_u    = fs ? '0 : row_r;
    row_ph_u = fs ? '0 : row_ph_r;
    row_q_u  = fs ? '0 : row_q_r;
    cnt_u    = fs ? '0 : cnt_r;
    step_u   = fs ? geom.step_new : geom.step_cur;
    fset     = fs ? geom.fit_new : geom.fit_cur;
    gset     = (geom.mode == fcb_pkg::MODE_CROP) ? geom.crop : fset;

    live = row_u < geom.ih;

    fit_keep = (col_ph_u == '0) && (row_ph_u == '0) &&
               (fcb_pkg::DIM_W'(col_q_u) < fset.dw) &&
               (fcb_pkg::DIM_W'(row_q_u) < fset.dh);

    dxc = fcb_pkg::DIM_W'(col_u) - geom.sx0;
    dyc = row_u - geom.sy0;
    crop_keep = (fcb_pkg::DIM_W'(col_u) >= geom.sx0) && (row_u >= geom.sy0) &&
                (dxc < geom.crop.dw) && (dyc < geom.crop.dh);

    keep = live && ((geom.mode == fcb_pkg::MODE_CROP) ? crop_keep : fit_keep);
    dx   = (geom.mode == fcb_pkg::MODE_CROP) ? dxc : fcb_pkg::DIM_W'(col_q_u);
    dy   = (geom.mode == fcb_pkg::MODE_CROP) ? dyc : fcb_pkg::DIM_W'(row_q_u);

    q_push           = take && keep;
    q_entry.row_term = gset.oy + fcb_pkg::ADDR_W'(dy);
    q_entry.col_term = gset.ox + fcb_pkg::ADDR_W'(dx);
    q_entry.pixel    = in_ch.pixel_in;
    q_entry.done     = cnt_u == gset.total_m1;

    // Advance the raster position and the decimation phases.
    col_inc     = fcb_pkg::DIM_W'(col_u) + fcb_pkg::DIM_W'(1);
    col_wrap    = col_inc >= geom.iw;
    col_ph_inc  = fcb_pkg::DIM_W'(col_ph_u) + fcb_pkg::DIM_W'(1);
    col_ph_wrap = col_ph_inc == step_u;
    row_ph_inc  = fcb_pkg::DIM_W'(row_ph_u) + fcb_pkg::DIM_W'(1);
    row_ph_wrap = row_ph_inc == step_u;

    col_nxt    = col_u;
    col_ph_nxt = col_ph_u;
    col_q_nxt  = col_q_u;
    row_nxt    = row_u;
    row_ph_nxt = row_ph_u;
    row_q_nxt  = row_q_u;
    cnt_nxt    = cnt_u + fcb_pkg::ADDR_W'(keep);
    if (live) begin
      if (col_wrap) begin
        col_nxt    = '0;
        col_ph_nxt = '0;
        col_q_nxt  = '0;
        row_nxt    = row_u + fcb_pkg::DIM_W'(1);
        row_ph_nxt = row_ph_wrap ? '0 : fcb_pkg::COL_W'(row_ph_inc);
        row_q_nxt  = row_ph_wrap ? row_q_u + fcb_pkg::COL_W'(1) : row_q_u;
      end else begin
        col_nxt    = fcb_pkg::COL_W'(col_inc);
        col_ph_nxt = col_ph_wrap ? '0 : fcb_pkg::COL_W'(col_ph_inc);
        col_q_nxt  = col_ph_wrap ? col_q_u + fcb_pkg::COL_W'(1) : col_q_u;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      col_ph_r <= '0;
      col_q_r  <= '0;
      row_r    <= '0;
      row_ph_r <= '0;
      row_q_r  <= '0;
      cnt_r    <= '0;
    end else if (take) begin
      col_r    <= col_nxt;
      col_ph_r <= col_ph_nxt;
      col_q_r  <= col_q_nxt;
      row_r    <= row_nxt;
      row_ph_r <= row_ph_nxt;
      row_q_r  <= row_q_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// File: rtl/fcb_queue.sv
// Short FIFO of kept pixels between the front end and the address back end.
// Depends on fcb_pkg for the entry type and depth.
module fcb_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  fcb_pkg::entry_t  push_entry,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output fcb_pkg::entry_t  head
);

  fcb_pkg::entry_t             mem_r [fcb_pkg::QUEUE_DEPTH];
  logic [fcb_pkg::QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [fcb_pkg::QCNT_W-1:0]  cnt_r;
  logic                        do_push, do_pop;

  assign full      = cnt_r == fcb_pkg::QCNT_W'(fcb_pkg::QUEUE_DEPTH);
  assign not_empty = cnt_r != '0;
  assign head      = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == fcb_pkg::QPTR_W'(fcb_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : wr_ptr_r + fcb_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == fcb_pkg::QPTR_W'(fcb_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : rd_ptr_r + fcb_pkg::QPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + fcb_pkg::QCNT_W'(1);
        2'b01:   cnt_r <= cnt_r - fcb_pkg::QCNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// File: rtl/fcb_back.sv
// Back end: row multiply stage, then address add into the output register.
// Depends on fcb_pkg and fcb_res_if; drains the queue.
module fcb_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_valid,
  input  fcb_pkg::entry_t           q_head,
  output logic                      q_pop,
  input  logic [fcb_pkg::DIM_W-1:0] sw,
  fcb_res_if.source                 out_ch
);

  logic                       s1_valid_r, out_valid_r;
  logic [fcb_pkg::ADDR_W-1:0] s1_base_r, s1_col_r, addr_r;
  logic [fcb_pkg::PIX_W-1:0]  s1_pix_r, pix_r;
  logic                       s1_done_r, done_r;
  logic [fcb_pkg::PROD_W-1:0] prod;
  logic                       out_load, s1_adv;

  assign out_load = !out_valid_r || out_ch.ready;
  assign s1_adv   = !s1_valid_r || out_load;
  assign q_pop    = q_valid && s1_adv;
  assign prod     = fcb_pkg::PROD_W'(q_head.row_term) * fcb_pkg::PROD_W'(sw);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid_r <= q_valid;
      end
      if (out_load) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_base_r <= prod[fcb_pkg::ADDR_W-1:0];
      s1_col_r  <= q_head.col_term;
      s1_pix_r  <= q_head.pixel;
      s1_done_r <= q_head.done;
    end
    if (out_load && s1_valid_r) begin
      addr_r <= s1_base_r + s1_col_r;
      pix_r  <= s1_pix_r;
      done_r <= s1_done_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.dest_addr  = addr_r;
  assign out_ch.pixel_out  = pix_r;
  assign out_ch.frame_done = done_r;

endmodule
